@@ hw/rtl/frm_pkg.sv @@
// ----------------------------------------------------------------------------
// frm_pkg
// Shared types and constants of the fragment reassembler.
// ----------------------------------------------------------------------------
package frm_pkg;

    localparam int BUF_DEPTH = 512;
    localparam int AW        = $clog2(BUF_DEPTH);
    localparam int CNT_W     = $clog2(BUF_DEPTH + 1);
    localparam int POS_W     = $clog2(BUF_DEPTH + 3);
    localparam int SUM_W     = POS_W + 1;
    localparam int MLEN_W    = 10;
    localparam int IDX_W     = 9;
    localparam int OQ_DEPTH  = 3;

    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(BUF_DEPTH + 2);

    localparam logic [7:0] HS_BYTE0   = 8'hA5;
    localparam logic [7:0] HS_BYTE1   = 8'h01;
    localparam int         FLAG_FIRST = 6;
    localparam int         FLAG_LAST  = 7;

    typedef enum logic [1:0] {
        OP_WRITE      = 2'd0,
        OP_CONNECT    = 2'd1,
        OP_DISCONNECT = 2'd2,
        OP_READ       = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_NONE     = 3'd0,
        ST_HS_OK    = 3'd1,
        ST_COMPLETE = 3'd2,
        ST_SEQ_ERR  = 3'd3,
        ST_OVERFLOW = 3'd4,
        ST_IGNORED  = 3'd5,
        ST_READ     = 3'd6
    } status_t;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [7:0]       data_byte;
        logic             last_byte;
        logic [IDX_W-1:0] read_index;
    } item_t;

    typedef struct packed {
        logic          we;
        logic [AW-1:0] waddr;
        logic [7:0]    wdata;
        logic          re;
        logic [AW-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [MLEN_W-1:0] message_length;
        logic              link_ready;
        logic              rd_en;
    } meta_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [MLEN_W-1:0] message_length;
        logic [7:0]        read_data;
        logic              link_ready;
    } result_t;

endpackage

@@ hw/rtl/frm_in_if.sv @@
// ----------------------------------------------------------------------------
// frm_in_if
// Input channel: one event, write byte or read request per beat.
// ----------------------------------------------------------------------------
interface frm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] data_byte;
    logic       last_byte;
    logic [8:0] read_index;

    modport source (output valid, output opcode, output data_byte, output last_byte,
                    output read_index, input ready);
    modport sink   (input valid, input opcode, input data_byte, input last_byte,
                    input read_index, output ready);
endinterface

@@ hw/rtl/frm_out_if.sv @@
// ----------------------------------------------------------------------------
// frm_out_if
// Result channel: one result per accepted input beat.
// ----------------------------------------------------------------------------
interface frm_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [9:0] message_length;
    logic [7:0] read_data;
    logic       link_ready;

    modport source (output valid, output status, output message_length, output read_data,
                    output link_ready, input ready);
    modport sink   (input valid, input status, input message_length, input read_data,
                    input link_ready, output ready);
endinterface

@@ hw/rtl/fragment_reassembler_with_handshake_top.sv @@
// ----------------------------------------------------------------------------
// fragment_reassembler_with_handshake_top
// Link handshake, fragment reassembly with sequence check, read-back by index.
// ----------------------------------------------------------------------------
// Usage:
//   req  : one beat per event, write byte or read request (opcode selects).
//          Write beats carry one byte of an incoming write; last_byte marks
//          its final byte. Connect/disconnect are single beats.
//   rsp  : exactly one result beat per accepted req beat, in order: status,
//          message length on completion, store byte on a read, link_ready.
// Timing:
//   A beat is accepted on the edge where valid and ready are both high.
//   All state updates and the store access happen on that edge; the result
//   enters the queue on the next edge and shows on rsp right after it.
//   Throughput is one beat per cycle while req.ready is high: the store has
//   one write and one read port, and every decision is one compare/add on
//   registered state.
// Stall:
//   Results wait in a three-entry output queue; req.ready drops only while
//   the queue plus the beat in flight already hold three results, so no
//   result is lost.
// Reset:
//   rst_n clears link, handshake and assembly state and empties the queue.
//   Store not cleared; user must read only written bytes, block does not check.
// ----------------------------------------------------------------------------
module fragment_reassembler_with_handshake_top (
    input  logic     clk,
    input  logic     rst_n,
    frm_in_if.sink   req,
    frm_out_if.source rsp
);
    import frm_pkg::*;

    logic     accept;
    logic     room;
    item_t    item;
    mem_req_t mem_req;
    meta_t    meta;
    logic [7:0] rdata;

    assign req.ready = room;
    assign accept    = req.valid & room;

    assign item.opcode     = req.opcode;
    assign item.data_byte  = req.data_byte;
    assign item.last_byte  = req.last_byte;
    assign item.read_index = req.read_index;

    // state and decisions, one accepted beat per cycle
    frm_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .item    (item),
        .mem_req (mem_req),
        .meta    (meta)
    );

    // payload bytes; read data is registered and lands in the cycle after the request
    frm_store u_store (
        .clk     (clk),
        .mem_req (mem_req),
        .rdata   (rdata)
    );

    // merges read data and decouples the result side
    frm_outq u_outq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (accept),
        .meta  (meta),
        .rdata (rdata),
        .room  (room),
        .rsp   (rsp)
    );

endmodule

@@ hw/rtl/frm_store.sv @@
// ----------------------------------------------------------------------------
// frm_store
// Message byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module frm_store (
    input  logic               clk,
    input  frm_pkg::mem_req_t  mem_req,
    output logic [7:0]         rdata
);
    import frm_pkg::*;

    logic [7:0] mem [BUF_DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_req.we)
        begin
            mem[mem_req.waddr] <= mem_req.wdata;
        end
        if (mem_req.re)
        begin
            rdata_reg <= mem[mem_req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/frm_ctrl.sv @@
// ----------------------------------------------------------------------------
// frm_ctrl
// Link, handshake and fragment state; issues store accesses per beat.
// ----------------------------------------------------------------------------
module frm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  frm_pkg::item_t    item,
    output frm_pkg::mem_req_t mem_req,
    output frm_pkg::meta_t    meta
);
    import frm_pkg::*;

    logic             link_up_reg,    link_up_next;
    logic             hs_ok_reg,      hs_ok_next;
    logic             active_reg,     active_next;
    logic [CNT_W-1:0] count_reg,      count_next;
    logic [7:0]       next_seq_reg,   next_seq_next;
    logic [POS_W-1:0] wpos_reg,       wpos_next;
    logic [15:0]      hdr_reg,        hdr_next;

    logic [15:0]      hdr_cur;
    logic [7:0]       seq;
    logic [7:0]       flg;
    logic             first_f;
    logic             seq_match;
    logic             frag_ok;
    logic [SUM_W-1:0] base;
    logic [SUM_W-1:0] pos_ext;
    logic [SUM_W-1:0] addr;
    logic [SUM_W-1:0] pl;
    logic [SUM_W-1:0] sum;
    logic             ovf;
    logic             pos0;
    logic             pos1;
    logic             rd_in_range;

    // header as seen after this byte
    always_comb
    begin
        hdr_cur = hdr_reg;
        if (pos0)
        begin
            hdr_cur[7:0] = item.data_byte;
        end
        else if (pos1)
        begin
            hdr_cur[15:8] = item.data_byte;
        end
    end

    assign pos0      = (wpos_reg == '0);
    assign pos1      = (wpos_reg == POS_W'(1));
    assign seq       = hdr_cur[7:0];
    assign flg       = hdr_cur[15:8];
    assign first_f   = flg[FLAG_FIRST];
    assign seq_match = (seq == next_seq_reg);
    assign frag_ok   = first_f | (active_reg & seq_match);
    assign base      = first_f ? '0 : SUM_W'(count_reg);
    assign pos_ext   = SUM_W'(wpos_reg);
    assign addr      = base + pos_ext - SUM_W'(2);
    assign pl        = pos_ext - SUM_W'(1);
    assign sum       = base + pl;
    assign ovf       = (pl > SUM_W'(BUF_DEPTH)) | (sum > SUM_W'(BUF_DEPTH));
    assign rd_in_range = (32'(item.read_index) < BUF_DEPTH);

    always_comb
    begin
        link_up_next  = link_up_reg;
        hs_ok_next    = hs_ok_reg;
        active_next   = active_reg;
        count_next    = count_reg;
        next_seq_next = next_seq_reg;
        wpos_next     = wpos_reg;
        hdr_next      = hdr_reg;

        mem_req.we    = 1'b0;
        mem_req.waddr = AW'(addr);
        mem_req.wdata = item.data_byte;
        mem_req.re    = 1'b0;
        mem_req.raddr = AW'(item.read_index);

        meta.status         = ST_NONE;
        meta.message_length = '0;
        meta.rd_en          = 1'b0;

        if (accept)
        begin
            unique case (opcode_t'(item.opcode))
                OP_WRITE:
                begin
                    if (!link_up_reg)
                    begin
                        if (item.last_byte)
                        begin
                            meta.status = ST_IGNORED;
                        end
                    end
                    else
                    begin
                        hdr_next = hdr_cur;
                        if (!pos0 && !pos1 && hs_ok_reg && frag_ok &&
                            (addr < SUM_W'(BUF_DEPTH)))
                        begin
                            mem_req.we = 1'b1;
                        end

                        if (!item.last_byte)
                        begin
                            if (wpos_reg < POS_LIMIT)
                            begin
                                wpos_next = wpos_reg + POS_W'(1);
                            end
                        end
                        else
                        begin
                            wpos_next = '0;
                            if (!hs_ok_reg)
                            begin
                                if (pos1 && hdr_cur[7:0] == HS_BYTE0 &&
                                    hdr_cur[15:8] == HS_BYTE1)
                                begin
                                    hs_ok_next  = 1'b1;
                                    meta.status = ST_HS_OK;
                                end
                                else
                                begin
                                    meta.status = ST_IGNORED;
                                end
                            end
                            else if (pos0)
                            begin
                                meta.status = ST_IGNORED;
                            end
                            else if (!first_f && !(active_reg && seq_match))
                            begin
                                // continuation out of order or with no open message
                                active_next = 1'b0;
                                count_next  = '0;
                                meta.status = ST_SEQ_ERR;
                            end
                            else
                            begin
                                next_seq_next = seq + 8'd1;
                                if (ovf)
                                begin
                                    active_next = 1'b0;
                                    count_next  = '0;
                                    meta.status = ST_OVERFLOW;
                                end
                                else if (flg[FLAG_LAST])
                                begin
                                    active_next = 1'b0;
                                    count_next  = '0;
                                    if (sum != '0)
                                    begin
                                        meta.status         = ST_COMPLETE;
                                        meta.message_length = MLEN_W'(sum);
                                    end
                                end
                                else
                                begin
                                    active_next = 1'b1;
                                    count_next  = CNT_W'(sum);
                                end
                            end
                        end
                    end
                end
                OP_CONNECT:
                begin
                    link_up_next = 1'b1;
                    hs_ok_next   = 1'b0;
                end
                OP_DISCONNECT:
                begin
                    link_up_next  = 1'b0;
                    hs_ok_next    = 1'b0;
                    active_next   = 1'b0;
                    count_next    = '0;
                    next_seq_next = '0;
                    wpos_next     = '0;
                    hdr_next      = '0;
                end
                OP_READ:
                begin
                    meta.status = ST_READ;
                    meta.rd_en  = rd_in_range;
                    mem_req.re  = 1'b1;
                end
            endcase
        end

        meta.link_ready = link_up_next & hs_ok_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_up_reg  <= 1'b0;
            hs_ok_reg    <= 1'b0;
            active_reg   <= 1'b0;
            count_reg    <= '0;
            next_seq_reg <= '0;
            wpos_reg     <= '0;
            hdr_reg      <= '0;
        end
        else
        begin
            link_up_reg  <= link_up_next;
            hs_ok_reg    <= hs_ok_next;
            active_reg   <= active_next;
            count_reg    <= count_next;
            next_seq_reg <= next_seq_next;
            wpos_reg     <= wpos_next;
            hdr_reg      <= hdr_next;
        end
    end

endmodule

@@ hw/rtl/frm_outq.sv @@
// ----------------------------------------------------------------------------
// frm_outq
// Joins result fields with store read data and queues results for output.
// ----------------------------------------------------------------------------
module frm_outq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  frm_pkg::meta_t  meta,
    input  logic [7:0]      rdata,
    output logic            room,
    frm_out_if.source       rsp
);
    import frm_pkg::*;

    logic             s1_valid_reg;
    meta_t            s1_meta_reg;
    result_t          fifo_reg [OQ_DEPTH];
    logic [1:0]       wr_ptr_reg, wr_ptr_next;
    logic [1:0]       rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg,  count_next;
    logic             pop;
    logic [2:0]       occupancy;
    result_t          s1_result;

    assign pop       = rsp.valid & rsp.ready;
    assign occupancy = {1'b0, count_reg} + {2'b00, s1_valid_reg};
    assign room      = (occupancy < 3'(OQ_DEPTH));

    always_comb
    begin
        s1_result.status         = s1_meta_reg.status;
        s1_result.message_length = s1_meta_reg.message_length;
        s1_result.link_ready     = s1_meta_reg.link_ready;
        s1_result.read_data      = s1_meta_reg.rd_en ? rdata : 8'd0;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (s1_valid_reg)
        begin
            wr_ptr_next = (wr_ptr_reg == 2'(OQ_DEPTH - 1)) ? 2'd0 : wr_ptr_reg + 2'd1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == 2'(OQ_DEPTH - 1)) ? 2'd0 : rd_ptr_reg + 2'd1;
        end
        count_next = count_reg + {1'b0, s1_valid_reg} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            count_reg    <= '0;
        end
        else
        begin
            s1_valid_reg <= push;
            wr_ptr_reg   <= wr_ptr_next;
            rd_ptr_reg   <= rd_ptr_next;
            count_reg    <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            s1_meta_reg <= meta;
        end
        if (s1_valid_reg)
        begin
            fifo_reg[wr_ptr_reg] <= s1_result;
        end
    end

    assign rsp.valid          = (count_reg != '0);
    assign rsp.status         = fifo_reg[rd_ptr_reg].status;
    assign rsp.message_length = fifo_reg[rd_ptr_reg].message_length;
    assign rsp.read_data      = fifo_reg[rd_ptr_reg].read_data;
    assign rsp.link_ready     = fifo_reg[rd_ptr_reg].link_ready;

endmodule

@@ tb/sv/frm_tb_pkg.sv @@
// ----------------------------------------------------------------------------
// frm_tb_pkg
// Reassembly scoreboard: predicts each result beat and checks the DUT output.
// ----------------------------------------------------------------------------
package frm_tb_pkg;

    import frm_pkg::*;

    class frag_scoreboard;

        // Link and assembly state, mirrored from the block
        bit        link_up;
        bit        hs_done;
        bit        assembling;
        int        asm_count;
        logic [7:0] next_seq;
        int        wpos;
        logic [15:0] hdr;              // [7:0] sequence byte, [15:8] flags byte
        logic [7:0] store [BUF_DEPTH];
        bit        written [BUF_DEPTH];

        result_t   expected_q [$];
        int        errors;

        // Predict the result of one accepted input beat and queue it.
        function void note_beat(item_t it);
            status_t st;
            result_t r;
            int      p;
            int      plen;
            int      addr;
            int      mlen;
            bit      chain_ok;
            logic [7:0] rd;

            st   = ST_NONE;
            mlen = 0;
            rd   = 8'h00;
            case (opcode_t'(it.opcode))
                OP_WRITE: begin
                    if (!link_up) begin
                        if (it.last_byte)
                            st = ST_IGNORED;
                    end
                    else begin
                        p = wpos;
                        if (p == 0)
                            hdr[7:0] = it.data_byte;
                        else if (p == 1)
                            hdr[15:8] = it.data_byte;
                        else if (hs_done && (hdr[8+FLAG_FIRST] ||
                                 (assembling && hdr[7:0] == next_seq))) begin
                            // payload lands in the store as it arrives
                            addr = (hdr[8+FLAG_FIRST] ? 0 : asm_count) + p - 2;
                            if (addr < BUF_DEPTH) begin
                                store[addr]   = it.data_byte;
                                written[addr] = 1'b1;
                            end
                        end

                        if (!it.last_byte) begin
                            if (wpos < BUF_DEPTH + 2)
                                wpos++;
                        end
                        else begin
                            wpos = 0;
                            if (!hs_done) begin
                                if (p == 1 && hdr == {HS_BYTE1, HS_BYTE0}) begin
                                    hs_done = 1'b1;
                                    st      = ST_HS_OK;
                                end
                                else
                                    st = ST_IGNORED;
                            end
                            else if (p == 0)
                                st = ST_IGNORED;
                            else begin
                                plen     = p - 1;
                                chain_ok = 1'b1;
                                if (hdr[8+FLAG_FIRST]) begin
                                    asm_count  = 0;
                                    assembling = 1'b1;
                                    next_seq   = hdr[7:0] + 8'd1;
                                end
                                else if (!assembling || hdr[7:0] != next_seq) begin
                                    assembling = 1'b0;
                                    asm_count  = 0;
                                    st         = ST_SEQ_ERR;
                                    chain_ok   = 1'b0;
                                end
                                else
                                    next_seq = hdr[7:0] + 8'd1;

                                if (chain_ok) begin
                                    if (asm_count + plen > BUF_DEPTH) begin
                                        assembling = 1'b0;
                                        asm_count  = 0;
                                        st         = ST_OVERFLOW;
                                    end
                                    else begin
                                        asm_count += plen;
                                        if (hdr[8+FLAG_LAST]) begin
                                            if (asm_count > 0) begin
                                                st   = ST_COMPLETE;
                                                mlen = asm_count;
                                            end
                                            assembling = 1'b0;
                                            asm_count  = 0;
                                        end
                                    end
                                end
                            end
                        end
                    end
                end
                OP_CONNECT: begin
                    link_up = 1'b1;
                    hs_done = 1'b0;
                end
                OP_DISCONNECT: begin
                    link_up    = 1'b0;
                    hs_done    = 1'b0;
                    assembling = 1'b0;
                    asm_count  = 0;
                    next_seq   = 8'h00;
                    wpos       = 0;
                    hdr        = 16'h0000;
                end
                OP_READ: begin
                    st = ST_READ;
                    rd = store[it.read_index];
                end
            endcase

            r.status         = st;
            r.message_length = mlen[MLEN_W-1:0];
            r.read_data      = rd;
            r.link_ready     = link_up && hs_done;
            expected_q.push_back(r);
        endfunction

        // Compare one result beat with the oldest prediction.
        function void check_result(result_t got);
            result_t want;

            if (expected_q.size() == 0) begin
                $error("unexpected result beat: status %0d", got.status);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.message_length !== want.message_length) begin
                $error("message_length: expected %0d, got %0d",
                       want.message_length, got.message_length);
                errors++;
            end
            if (got.read_data !== want.read_data) begin
                $error("read_data: expected 0x%02h, got 0x%02h", want.read_data, got.read_data);
                errors++;
            end
            if (got.link_ready !== want.link_ready) begin
                $error("link_ready: expected %0d, got %0d", want.link_ready, got.link_ready);
                errors++;
            end
        endfunction

        // Any store index that has been written, or -1 if none yet.
        function int pick_written();
            int start;

            start = $urandom_range(BUF_DEPTH - 1);
            for (int k = 0; k < BUF_DEPTH; k++)
                if (written[(start + k) % BUF_DEPTH])
                    return (start + k) % BUF_DEPTH;
            return -1;
        endfunction

    endclass

endpackage

@@ tb/sv/fragment_reassembler_with_handshake_top_tb.sv @@
// ----------------------------------------------------------------------------
// fragment_reassembler_with_handshake_top_tb
// Drives link events, write bytes and read-backs into the reassembler and
// checks every result beat against a scoreboard that tracks the link,
// handshake and fragment assembly state plus the byte store.
// ----------------------------------------------------------------------------
module fragment_reassembler_with_handshake_top_tb;

    import frm_pkg::*;
    import frm_tb_pkg::*;

    logic clk;
    logic rst_n;

    frm_in_if  req ();
    frm_out_if rsp ();

    fragment_reassembler_with_handshake_top uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    frag_scoreboard board = new();
    result_t        seen;

    // calm: no idling on either side while set (one long stretch of the random part)
    bit calm = 1'b0;
    // beats that actually reach the link logic; writes while the link is down do not count
    int counted;

    // ------------------------------------------------------------------------
    // Clock, 12 time units
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Run limit: far above the slowest legal run (about 1.5k beats with stalls)
    initial
    begin
        #7_200_000;
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: ready toggles at the falling edge, roughly 28% low
    // ------------------------------------------------------------------------
    initial
    begin
        rsp.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp.ready <= calm || ($urandom_range(99) >= 28);
        end
    end

    // Sample at the rising edge; DUT outputs still hold pre-edge values here
    always @(posedge clk)
    begin
        if (rst_n && rsp.valid === 1'b1 && rsp.ready === 1'b1)
        begin
            seen.status         = rsp.status;
            seen.message_length = rsp.message_length;
            seen.read_data      = rsp.read_data;
            seen.link_ready     = rsp.link_ready;
            board.check_result(seen);
        end
    end

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    // One beat: optional idle cycles, present at the falling edge, hold until
    // taken, then let the scoreboard predict it.
    task automatic send_beat(input opcode_t op, input logic [7:0] b, input logic lb,
                             input logic [8:0] idx);
        item_t it;

        @(negedge clk);
        while (!calm && $urandom_range(99) < 28)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid      <= 1'b1;
        req.opcode     <= op;
        req.data_byte  <= b;
        req.last_byte  <= lb;
        req.read_index <= idx;
        do
            @(posedge clk);
        while (req.ready !== 1'b1);

        if (op != OP_WRITE || board.link_up)
            counted++;
        it.opcode     = op;
        it.data_byte  = b;
        it.last_byte  = lb;
        it.read_index = idx;
        board.note_beat(it);
    endtask

    // Read back a byte that is known to be in the store
    task automatic send_read();
        int idx;

        idx = board.pick_written();
        if (idx >= 0)
            send_beat(OP_READ, 8'($urandom), 1'($urandom), idx[8:0]);
    endtask

    // One write of n bytes: b0/b1 are the first two (sequence and flags on a
    // fragment), the rest random payload. With mix set, reads may slip in
    // between payload bytes.
    task automatic send_write(input int n, input logic [7:0] b0, input logic [7:0] b1,
                              input bit mix);
        logic [7:0] b;

        for (int i = 0; i < n; i++)
        begin
            b = (i == 0) ? b0 : (i == 1) ? b1 : 8'($urandom);
            if (mix && i >= 2 && $urandom_range(99) < 4)
                send_read();
            send_beat(OP_WRITE, b, i == n - 1, 9'($urandom));
        end
    endtask

    // A message of 1..4 fragments, mostly well formed; now and then a flag
    // or sequence number is broken, and a few fragments are large.
    task automatic send_message();
        int         nfrag;
        int         plen;
        logic [7:0] seq;
        logic [7:0] flg;

        nfrag = $urandom_range(1, 4);
        seq   = 8'($urandom);
        for (int f = 0; f < nfrag; f++)
        begin
            flg = 8'h00;
            flg[FLAG_FIRST] = (f == 0);
            flg[FLAG_LAST]  = (f == nfrag - 1);
            if ($urandom_range(99) < 30)
                flg[5:0] = 6'($urandom);
            if ($urandom_range(99) < 6)
                flg[FLAG_FIRST] = ~flg[FLAG_FIRST];
            if ($urandom_range(99) < 6)
                seq = seq + 8'($urandom_range(1, 255));
            plen = ($urandom_range(99) < 3) ? $urandom_range(100, 520) : $urandom_range(0, 12);
            send_write(plen + 2, seq, flg, 1'b1);
            seq = seq + 8'd1;
        end
    endtask

    // Hold the sender until every queued result has come back
    task automatic drain_results();
        @(negedge clk);
        req.valid <= 1'b0;
        while (board.expected_q.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int roll;
        int next_drain;

        rst_n          = 1'b0;
        req.valid      = 1'b0;
        req.opcode     = OP_WRITE;
        req.data_byte  = 8'h00;
        req.last_byte  = 1'b0;
        req.read_index = 9'd0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // --- directed part -------------------------------------------------
        send_write(1, 8'hFF, 8'h00, 1'b0);          // link down: ignored
        send_write(3, 8'hA5, 8'h01, 1'b0);          // link down, multi-byte
        send_beat(OP_CONNECT, 8'h00, 1'b0, 9'd0);
        send_write(2, 8'hA5, 8'h02, 1'b0);          // wrong handshake byte
        send_write(3, 8'hA5, 8'h01, 1'b0);          // handshake too long
        send_write(2, HS_BYTE0, HS_BYTE1, 1'b0);    // handshake done
        send_write(1, 8'hA5, 8'h00, 1'b0);          // short write
        send_write(2, 8'h00, 8'hC0, 1'b0);          // empty message: no report
        send_write(5, 8'h07, 8'hC0, 1'b0);          // single fragment, 3 bytes
        send_write(4, 8'hFF, 8'h40, 1'b0);          // sequence wraps FF -> 00
        send_write(3, 8'h00, 8'h00, 1'b0);
        send_write(4, 8'h01, 8'h80, 1'b0);
        send_write(3, 8'h05, 8'h00, 1'b0);          // continuation, nothing open
        send_write(3, 8'h10, 8'h40, 1'b0);
        send_write(3, 8'h13, 8'h80, 1'b0);          // sequence gap
        send_write(BUF_DEPTH + 2, 8'h20, 8'hC0, 1'b0);  // fills the store exactly
        send_beat(OP_READ, 8'hFF, 1'b1, 9'd0);
        send_beat(OP_READ, 8'h00, 1'b0, 9'd511);
        send_write(12, 8'h30, 8'h40, 1'b0);
        send_write(530, 8'h31, 8'h80, 1'b0);        // overflows, position saturates
        send_beat(OP_CONNECT, 8'h00, 1'b0, 9'd0);   // reconnect drops handshake
        send_write(2, HS_BYTE0, HS_BYTE1, 1'b0);
        send_beat(OP_DISCONNECT, 8'h00, 1'b0, 9'd0);
        send_write(2, HS_BYTE0, HS_BYTE1, 1'b0);    // link down again
        send_beat(OP_CONNECT, 8'h00, 1'b0, 9'd0);
        drain_results();

        // --- random part ---------------------------------------------------
        counted    = 0;
        next_drain = 150;
        while (counted < 350)
        begin
            calm = (counted >= 100 && counted < 250);
            roll = $urandom_range(99);
            if (!board.link_up)
            begin
                if (roll < 15)
                    send_write($urandom_range(1, 4), 8'($urandom), 8'($urandom), 1'b0);
                else
                    send_beat(OP_CONNECT, 8'($urandom), 1'($urandom), 9'($urandom));
            end
            else if (!board.hs_done)
            begin
                if (roll < 75)
                    send_write(2, HS_BYTE0, HS_BYTE1, 1'b0);
                else if (roll < 92)
                    send_write($urandom_range(1, 3), 8'($urandom), 8'($urandom), 1'b0);
                else
                    send_beat(OP_DISCONNECT, 8'($urandom), 1'($urandom), 9'($urandom));
            end
            else
            begin
                if (roll < 55)
                    send_message();
                else if (roll < 70)
                    send_read();
                else if (roll < 78)
                    send_write($urandom_range(1, 8), 8'($urandom), 8'($urandom), 1'b0);
                else if (roll < 83)
                    send_write(1, 8'($urandom), 8'h00, 1'b0);
                else if (roll < 87)
                    send_beat(OP_CONNECT, 8'($urandom), 1'($urandom), 9'($urandom));
                else if (roll < 91)
                    send_beat(OP_DISCONNECT, 8'($urandom), 1'($urandom), 9'($urandom));
                else
                    repeat ($urandom_range(2, 5)) send_read();
            end
            if (counted >= next_drain)
            begin
                drain_results();
                next_drain += 150;
            end
        end
        calm = 1'b0;

        // --- wrap up ---------------------------------------------------------
        drain_results();
        repeat (8) @(posedge clk);
        if (board.expected_q.size() != 0)
            $error("%0d expected result beats never arrived", board.expected_q.size());
        if (board.errors == 0 && board.expected_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/frm_pkg.sv
hw/rtl/frm_in_if.sv
hw/rtl/frm_out_if.sv
hw/rtl/frm_store.sv
hw/rtl/frm_ctrl.sv
hw/rtl/frm_outq.sv
hw/rtl/fragment_reassembler_with_handshake_top.sv
tb/sv/frm_tb_pkg.sv
tb/sv/fragment_reassembler_with_handshake_top_tb.sv
